// ===== sv/speed_ramp_with_friction_core_macros.svh =====
// Assertion macros shared by the speed ramp core.
`ifndef SPEED_RAMP_WITH_FRICTION_CORE_MACROS_SVH
`define SPEED_RAMP_WITH_FRICTION_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SRWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srwf assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srwf assertion failed");

`endif

// ===== sv/srwf_pkg.sv =====
// ----------------------------------------------------------------------------
// srwf_pkg
// Types and constants of the speed ramp core with friction model.
// ----------------------------------------------------------------------------
package srwf_pkg;

  localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

  localparam int unsigned DIV_W     = 72;
  localparam int unsigned DIV_STEPS = DIV_W;

  localparam logic [7:0] REG_VEHICLE_MASS    = 8'd0;
  localparam logic [7:0] REG_LOAD_MASS       = 8'd1;
  localparam logic [7:0] REG_DRIVE_TORQUE    = 8'd2;
  localparam logic [7:0] REG_FRICTION_FACTOR = 8'd3;
  localparam logic [7:0] REG_SPEED_LIMIT     = 8'd4;
  localparam logic [7:0] REG_ACCEL_LIMIT     = 8'd5;
  localparam logic [7:0] REG_DECEL_LIMIT     = 8'd6;
  localparam logic [7:0] REG_WHEEL_SIZE      = 8'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRAV,
    S_FLO,
    S_FHI,
    S_DRV_DIV,
    S_NET,
    S_UP_DIV,
    S_DN_DIV
  } seq_state_e;

endpackage

// ===== sv/speed_ramp_with_friction_core.sv =====
// ----------------------------------------------------------------------------
// speed_ramp_with_friction_core
// Slew-rate limiter for linear speed, driven by a torque and friction model.
// ----------------------------------------------------------------------------
// Usage. Each input transaction carries the current speed, the target speed
// and a time step; one output transaction returns the next speed, in order.
// Both data channels use valid and stall: a transaction completes on a clock
// edge with valid high and stall low. Configuration registers are written
// through a valid/ready channel by register index; an index above seven is
// ignored.
// The acceleration magnitudes depend on configuration only. They are worked
// out by a sequencer with a bit-serial divider after reset and after each
// configuration write; during that time the input stalls and the
// configuration channel is not ready. The pipeline stages are select,
// multiply, add and range clamp, and target clamp. Throughput is one item
// per cycle while neither the receiver nor the sequencer stalls it.
// Reset is asynchronous and active low: registers return to their defaults
// and the pipeline empties. When the receiver stalls, each stage holds its
// item and empty stages keep filling, so input stall rises only once the
// pipeline is full.
// ----------------------------------------------------------------------------
module speed_ramp_with_friction_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] speed_now_i,
  input  logic signed [31:0] speed_goal_i,
  input  logic [23:0]        step_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] speed_next_o
);
  import srwf_pkg::*;

  `include "speed_ramp_with_friction_core_macros.svh"

  // Configuration registers.
  logic [31:0] vehicle_mass_q, load_mass_q, drive_torque_q, friction_factor_q, wheel_size_q;
  logic [30:0] speed_limit_q, accel_limit_q, decel_limit_q;
  logic        cfg_we;
  seq_state_e  st_q, st_d;

  assign cfg_ready_o = (st_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vehicle_mass_q    <= 32'd3276800;
      load_mass_q       <= 32'd0;
      drive_torque_q    <= 32'd655360;
      friction_factor_q <= 32'd6554;
      speed_limit_q     <= 31'd98304;
      accel_limit_q     <= 31'd65536;
      decel_limit_q     <= 31'd65536;
      wheel_size_q      <= 32'd6554;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_VEHICLE_MASS:    vehicle_mass_q    <= cfg_data_i;
        REG_LOAD_MASS:       load_mass_q       <= cfg_data_i;
        REG_DRIVE_TORQUE:    drive_torque_q    <= cfg_data_i;
        REG_FRICTION_FACTOR: friction_factor_q <= cfg_data_i;
        REG_SPEED_LIMIT:     speed_limit_q     <= cfg_data_i[30:0];
        REG_ACCEL_LIMIT:     accel_limit_q     <= cfg_data_i[30:0];
        REG_DECEL_LIMIT:     decel_limit_q     <= cfg_data_i[30:0];
        REG_WHEEL_SIZE:      wheel_size_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer for the configuration-derived magnitudes.
  logic [36:0] grav_q, grav_d;
  logic [47:0] plo_q, plo_d;
  logic [53:0] fric_q, fric_d;
  logic [47:0] drive_q, drive_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [30:0] mag_up_q, mag_up_d, mag_dn_q, mag_dn_d;
  logic [32:0] tm;
  logic [52:0] grav_prod;
  logic [33:0] rem_sh;
  logic        qbit;
  logic [DIV_W-1:0] quo;
  logic [53:0] net;
  logic        div_last;

  function automatic logic [30:0] sat_mag(input logic [DIV_W-1:0] q, input logic [30:0] lim);
    logic [30:0] r;
    if (|q[DIV_W-1:31]) r = lim;
    else if (q[30:0] < lim) r = q[30:0];
    else r = lim;
    return r;
  endfunction

  assign tm        = {1'b0, vehicle_mass_q} + {1'b0, load_mass_q};
  assign grav_prod = tm * GRAVITY_Q16;
  assign rem_sh    = {rem_q[32:0], dvd_q[DIV_W-1]};
  assign qbit      = (rem_sh >= {1'b0, dsr_q});
  assign quo       = {dvd_q[DIV_W-2:0], qbit};
  assign div_last  = (cnt_q == 7'(DIV_STEPS - 1));
  assign net       = ({6'd0, drive_q} > fric_q) ? ({6'd0, drive_q} - fric_q) : 54'd0;

  always_comb begin
    st_d     = st_q;
    grav_d   = grav_q;
    plo_d    = plo_q;
    fric_d   = fric_q;
    drive_d  = drive_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    cnt_d    = cnt_q;
    mag_up_d = mag_up_q;
    mag_dn_d = mag_dn_q;
    case (st_q)
      S_IDLE: begin
        if (cfg_we) st_d = S_GRAV;
      end
      S_GRAV: begin
        grav_d = grav_prod[52:16];
        st_d   = S_FLO;
      end
      S_FLO: begin
        plo_d = grav_q[15:0] * friction_factor_q;
        st_d  = S_FHI;
      end
      S_FHI: begin
        fric_d = 54'(grav_q[36:16] * friction_factor_q) + {22'd0, plo_q[47:16]};
        rem_d  = 34'd0;
        cnt_d  = 7'd0;
        dvd_d  = {24'd0, drive_torque_q, 16'd0};
        dsr_d  = {1'b0, wheel_size_q};
        if (wheel_size_q == 32'd0) begin
          drive_d = 48'd0;
          st_d    = S_NET;
        end else begin
          st_d = S_DRV_DIV;
        end
      end
      S_DRV_DIV: begin
        rem_d = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_d = quo;
        cnt_d = cnt_q + 7'd1;
        if (div_last) begin
          drive_d = quo[47:0];
          st_d    = S_NET;
        end
      end
      S_NET: begin
        rem_d = 34'd0;
        cnt_d = 7'd0;
        dvd_d = {2'd0, net, 16'd0};
        dsr_d = tm;
        if (tm == 33'd0) begin
          mag_up_d = 31'd0;
          mag_dn_d = 31'd0;
          st_d     = S_IDLE;
        end else begin
          st_d = S_UP_DIV;
        end
      end
      S_UP_DIV: begin
        rem_d = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_d = quo;
        cnt_d = cnt_q + 7'd1;
        if (div_last) begin
          mag_up_d = sat_mag(quo, accel_limit_q);
          rem_d    = 34'd0;
          cnt_d    = 7'd0;
          dvd_d    = {2'd0, fric_q, 16'd0};
          st_d     = S_DN_DIV;
        end
      end
      S_DN_DIV: begin
        rem_d = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_d = quo;
        cnt_d = cnt_q + 7'd1;
        if (div_last) begin
          mag_dn_d = sat_mag(quo, decel_limit_q);
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_GRAV;
      cnt_q    <= 7'd0;
      mag_up_q <= 31'd0;
      mag_dn_q <= 31'd0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      mag_up_q <= mag_up_d;
      mag_dn_q <= mag_dn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grav_q  <= grav_d;
    plo_q   <= plo_d;
    fric_q  <= fric_d;
    drive_q <= drive_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
  end

  // Item pipeline. Each stage takes a new item when empty or moving on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4, in_acc;

  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = (st_q != S_IDLE) || !en1;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_acc;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage one: direction and magnitude.
  logic signed [31:0] now1_q, goal1_q;
  logic [23:0] dt1_q;
  logic        up1_q, eq1_q;
  logic [30:0] mag1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      now1_q  <= speed_now_i;
      goal1_q <= speed_goal_i;
      dt1_q   <= step_time_i;
      up1_q   <= speed_goal_i > speed_now_i;
      eq1_q   <= speed_goal_i == speed_now_i;
      mag1_q  <= (speed_goal_i > speed_now_i) ? mag_up_q : mag_dn_q;
    end
  end

  // Stage two: change of speed over the time step.
  logic signed [31:0] now2_q, goal2_q;
  logic        up2_q, eq2_q;
  logic [38:0] delta2_q;
  logic [54:0] step_prod;

  assign step_prod = mag1_q * dt1_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      now2_q   <= now1_q;
      goal2_q  <= goal1_q;
      up2_q    <= up1_q;
      eq2_q    <= eq1_q;
      delta2_q <= step_prod[54:16];
    end
  end

  // Stage three: new speed, clamped to the range zero to the speed limit.
  logic signed [31:0] now3_q, goal3_q;
  logic        up3_q, eq3_q;
  logic [30:0] rng3_q;
  logic signed [40:0] nx;
  logic [30:0] rng;

  always_comb begin
    if (up2_q) nx = 41'(now2_q) + $signed({2'b00, delta2_q});
    else       nx = 41'(now2_q) - $signed({2'b00, delta2_q});
    if (nx[40]) rng = 31'd0;
    else if (nx[39:0] > {9'd0, speed_limit_q}) rng = speed_limit_q;
    else rng = nx[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      now3_q  <= now2_q;
      goal3_q <= goal2_q;
      up3_q   <= up2_q;
      eq3_q   <= eq2_q;
      rng3_q  <= rng;
    end
  end

  // Stage four: do not pass the target; equal speeds pass through untouched.
  logic signed [32:0] rx, gx;
  logic signed [31:0] res;

  assign rx = $signed({2'b00, rng3_q});
  assign gx = 33'(goal3_q);

  always_comb begin
    if (eq3_q) res = now3_q;
    else if (up3_q && (rx > gx)) res = goal3_q;
    else if (!up3_q && (rx < gx)) res = goal3_q;
    else res = $signed({1'b0, rng3_q});
  end

  always_ff @(posedge clk_i) begin
    if (en4) speed_next_o <= res;
  end

  assign out_valid_o = v4_q;

  `SRWF_ASSERT_NOW(a_busy_stalls, st_q != S_IDLE, in_stall_o && !cfg_ready_o)
  `SRWF_ASSERT_NEXT(a_write_recomputes, cfg_we, st_q == S_GRAV)
  `SRWF_ASSERT_NOW(a_mag_limited, st_q == S_IDLE,
                   (mag_up_q <= accel_limit_q) && (mag_dn_q <= decel_limit_q))

endmodule
